// ===== hdl/knob_angle_tracker_defines.svh =====
// ----------------------------------------------------------------------------
// knob_angle_tracker_defines.svh
// Assertion macros shared by the knob angle tracker RTL.
// ----------------------------------------------------------------------------
`ifndef KNOB_ANGLE_TRACKER_DEFINES_SVH
`define KNOB_ANGLE_TRACKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KAT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/kat_pkg.sv =====
// ----------------------------------------------------------------------------
// kat_pkg
// Constants, register indexes and sequencer states of the knob angle tracker.
// ----------------------------------------------------------------------------
package kat_pkg;

    // One full turn of the sensor and of the transfer table, tenths of a degree.
    localparam int FULL_TURN  = 3600;
    localparam int HALF_TURN  = FULL_TURN / 2;
    localparam int TABLE_SPAN = 3600;

    // Modulo reduction subtracts FULL_TURN << k for k = MOD_STEPS-1 down to 0.
    localparam int MOD_STEPS = 5;
    localparam logic [16:0] MOD_UNIT = 17'(FULL_TURN);
    localparam logic [16:0] MOD_BIAS = 17'(FULL_TURN << (MOD_STEPS - 1));

    // Detent rounding divides a 16-bit magnitude one quotient bit per cycle.
    localparam int DIV_STEPS = 16;

    // Half an LSB of the Q8.8 stretch product.
    localparam logic [31:0] ROUND_Q8 = 32'd128;

    // Configuration register indexes.
    localparam logic [2:0] CFG_WRAP_OUTPUT  = 3'd0;
    localparam logic [2:0] CFG_MIN_ANGLE    = 3'd1;
    localparam logic [2:0] CFG_MAX_ANGLE    = 3'd2;
    localparam logic [2:0] CFG_WRAP_INDEX   = 3'd3;
    localparam logic [2:0] CFG_STRETCH_Q8   = 3'd4;
    localparam logic [2:0] CFG_DETENT_STEP  = 3'd5;
    localparam logic [2:0] CFG_INDEX_OFFSET = 3'd6;

    // Register reset values.
    localparam logic signed [15:0] MIN_ANGLE_RST = 16'sd0;
    localparam logic signed [15:0] MAX_ANGLE_RST = 16'sd3600;
    localparam logic [15:0]        STRETCH_RST   = 16'd256;
    localparam logic [14:0]        DETENT_RST    = 15'd3600;

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_UNWRAP  = 12'b0000_0000_0010,
        S_OSHAPE  = 12'b0000_0000_0100,
        S_OMOD    = 12'b0000_0000_1000,
        S_MUL     = 12'b0000_0001_0000,
        S_IDX     = 12'b0000_0010_0000,
        S_IMOD    = 12'b0000_0100_0000,
        S_DIVPREP = 12'b0000_1000_0000,
        S_DIV     = 12'b0001_0000_0000,
        S_DMUL    = 12'b0010_0000_0000,
        S_TRIG    = 12'b0100_0000_0000,
        S_DONE    = 12'b1000_0000_0000
    } t_state;

endpackage

// ===== hdl/knob_angle_tracker.sv =====
// ----------------------------------------------------------------------------
// knob_angle_tracker
// Unwraps absolute knob angle samples into steps, counts turns, and keeps a
// shaped output angle, a stretched table index and a detent trigger.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                    Payload
//   input     in         i_in_valid / o_in_stall      i_cmd, i_raw_angle
//   result    out        o_out_valid / i_out_stall    o_step_delta .. o_trigger_bit
//   config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// A sample request runs from acceptance to the result register through the sequencer
// states in order; each modulo reduction adds 5 subtractor passes, and the 16-step
// restoring divider and two multiplier passes always run. A restart request skips
// to the final state. The input stalls until the sequencer is idle.
// Reset is synchronous and active low; it restores control, configuration and tracking state.
// A result held by a stalled consumer only blocks the sequencer in its last state.
// ----------------------------------------------------------------------------
`include "knob_angle_tracker_defines.svh"

module knob_angle_tracker (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_cmd,
    input  logic [11:0]        i_raw_angle,

    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [11:0] o_step_delta,
    output logic signed [15:0] o_turn_count,
    output logic signed [31:0] o_total_angle,
    output logic signed [15:0] o_shaped_angle,
    output logic [11:0]        o_table_index,
    output logic signed [16:0] o_detent_angle,
    output logic               o_trigger_bit,

    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);

    localparam logic [15:0] OUT_SPAN = 16'(kat_pkg::FULL_TURN);
    localparam logic [11:0] IDX_SPAN = 12'(kat_pkg::TABLE_SPAN);

    // Sequencer state.
    kat_pkg::t_state r_state, n_state;
    logic            r_out_valid;

    // Configuration registers.
    logic               r_cfg_wrap_output;
    logic signed [15:0] r_cfg_min;
    logic signed [15:0] r_cfg_max;
    logic               r_cfg_wrap_index;
    logic [15:0]        r_cfg_stretch;
    logic [14:0]        r_cfg_detent;
    logic [11:0]        r_cfg_offset;

    // Tracking state kept between requests.
    logic [11:0]        r_prev_raw;
    logic [15:0]        r_turns;
    logic [31:0]        r_total;
    logic [15:0]        r_out;
    logic [15:0]        r_index;
    logic signed [16:0] r_last_det;
    logic               r_trig;

    // Working registers of the current request.
    logic               r_cmd;
    logic [11:0]        r_raw;
    logic signed [12:0] r_delta;
    logic signed [16:0] r_o;
    logic [16:0]        r_rem;
    logic [15:0]        r_quo;
    logic [3:0]         r_cnt;
    logic [31:0]        r_prod;
    logic [11:0]        r_tidx;
    logic signed [16:0] r_det;

    // Result register.
    logic [11:0]        r_res_step;
    logic [15:0]        r_res_turns;
    logic [31:0]        r_res_total;
    logic [15:0]        r_res_shaped;
    logic [11:0]        r_res_tidx;
    logic [16:0]        r_res_det;
    logic               r_res_trig;

    // Combinational datapath.
    logic [14:0]        res;
    logic signed [12:0] raw_diff;
    logic signed [12:0] n_delta;
    logic signed [16:0] n_o;
    logic [16:0]        o_clamp;
    logic [16:0]        o_biased;
    logic [12:0]        delta_abs;
    logic [31:0]        prod_round;
    logic [15:0]        q16;
    logic [15:0]        n_index;
    logic [11:0]        idx_clamp;
    logic [16:0]        idx_biased;
    logic [16:0]        shaped_abs;
    logic [16:0]        div_num;
    logic [16:0]        sub_a;
    logic [16:0]        sub_b;
    logic [17:0]        sub_diff;
    logic               sub_ge;
    logic [16:0]        n_rem;
    logic [15:0]        mul_a;
    logic [15:0]        mul_b;
    logic [31:0]        mul_p;
    logic [15:0]        det_mag;
    logic [17:0]        det_diff;
    logic [17:0]        det_diff_abs;
    logic               res_load;
    logic               in_accept;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != kat_pkg::S_IDLE);
    assign o_cfg_ready = (r_state == kat_pkg::S_IDLE);
    assign res_load    = (r_state == kat_pkg::S_DONE) && (!r_out_valid || !i_out_stall);

    // A detent step of zero behaves as a step of one.
    assign res = (r_cfg_detent == 15'd0) ? 15'd1 : r_cfg_detent;

    // Unwrap across the seam: any jump larger than half a turn is taken the
    // short way round, and the turn counter moves against it.
    always_comb begin
        raw_diff = $signed({1'b0, r_raw}) - $signed({1'b0, r_prev_raw});
        if (raw_diff < -$signed(13'(kat_pkg::HALF_TURN))) begin
            n_delta = raw_diff + $signed(13'(kat_pkg::FULL_TURN));
        end else if (raw_diff > $signed(13'(kat_pkg::HALF_TURN))) begin
            n_delta = raw_diff - $signed(13'(kat_pkg::FULL_TURN));
        end else begin
            n_delta = raw_diff;
        end
        n_o = $signed({r_out[15], r_out}) + $signed({{4{n_delta[12]}}, n_delta});
    end

    // Clamp: limit to max first, then raise to min, so min wins when crossed.
    // Negative values get a whole multiple of a turn added before reduction.
    always_comb begin
        if (r_o > $signed({r_cfg_max[15], r_cfg_max})) begin
            o_clamp = {r_cfg_max[15], r_cfg_max};
        end else begin
            o_clamp = r_o;
        end
        if ($signed(o_clamp) < $signed({r_cfg_min[15], r_cfg_min})) begin
            o_clamp = {r_cfg_min[15], r_cfg_min};
        end
        o_biased = r_o[16] ? (r_o + kat_pkg::MOD_BIAS) : r_o;
    end

    // Stretched step: |delta| * Q8.8, rounded half away from zero, 16 bits kept.
    always_comb begin
        delta_abs  = r_delta[12] ? 13'(-r_delta) : 13'(r_delta);
        prod_round = r_prod + kat_pkg::ROUND_Q8;
        q16        = r_delta[12] ? 16'(-prod_round[23:8]) : prod_round[23:8];
        n_index    = r_index + q16;
        if (n_index[15]) begin
            idx_clamp = 12'd0;
        end else if (n_index > 16'(kat_pkg::TABLE_SPAN)) begin
            idx_clamp = IDX_SPAN;
        end else begin
            idx_clamp = n_index[11:0];
        end
        idx_biased = n_index[15] ? ({1'b1, n_index} + kat_pkg::MOD_BIAS) : {1'b0, n_index};
    end

    // Dividend for detent rounding: |shaped| + res/2 never exceeds 16 bits.
    always_comb begin
        shaped_abs = r_out[15] ? 17'(-{r_out[15], r_out}) : {1'b0, r_out};
        div_num    = shaped_abs + {3'b000, res[14:1]};
    end

    // Shared subtract-and-compare unit for both modulo reductions and the divider.
    always_comb begin
        if (r_state == kat_pkg::S_DIV) begin
            sub_a = {r_rem[15:0], r_quo[15]};
            sub_b = {2'b00, res};
        end else begin
            sub_a = r_rem;
            sub_b = kat_pkg::MOD_UNIT << r_cnt;
        end
        sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
        sub_ge   = !sub_diff[17];
        n_rem    = sub_ge ? sub_diff[16:0] : sub_a;
    end

    // Shared multiplier: stretch product, then detent quotient times step.
    always_comb begin
        if (r_state == kat_pkg::S_DMUL) begin
            mul_a = r_quo;
            mul_b = {1'b0, res};
        end else begin
            mul_a = {4'd0, delta_abs[11:0]};
            mul_b = r_cfg_stretch;
        end
        mul_p   = mul_a * mul_b;
        det_mag = mul_p[15:0];
    end

    // The trigger toggles once the detent has moved by a full step or more.
    always_comb begin
        det_diff     = $signed({r_det[16], r_det}) - $signed({r_last_det[16], r_last_det});
        det_diff_abs = det_diff[17] ? 18'(-det_diff) : det_diff;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kat_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_state = kat_pkg::S_UNWRAP;
                end
            end
            kat_pkg::S_UNWRAP: begin
                n_state = r_cmd ? kat_pkg::S_DONE : kat_pkg::S_OSHAPE;
            end
            kat_pkg::S_OSHAPE: begin
                n_state = r_cfg_wrap_output ? kat_pkg::S_OMOD : kat_pkg::S_MUL;
            end
            kat_pkg::S_OMOD: begin
                if (r_cnt == 4'd0) begin
                    n_state = kat_pkg::S_MUL;
                end
            end
            kat_pkg::S_MUL: begin
                n_state = kat_pkg::S_IDX;
            end
            kat_pkg::S_IDX: begin
                n_state = r_cfg_wrap_index ? kat_pkg::S_IMOD : kat_pkg::S_DIVPREP;
            end
            kat_pkg::S_IMOD: begin
                if (r_cnt == 4'd0) begin
                    n_state = kat_pkg::S_DIVPREP;
                end
            end
            kat_pkg::S_DIVPREP: begin
                n_state = kat_pkg::S_DIV;
            end
            kat_pkg::S_DIV: begin
                if (r_cnt == 4'd0) begin
                    n_state = kat_pkg::S_DMUL;
                end
            end
            kat_pkg::S_DMUL: begin
                n_state = kat_pkg::S_TRIG;
            end
            kat_pkg::S_TRIG: begin
                n_state = kat_pkg::S_DONE;
            end
            kat_pkg::S_DONE: begin
                if (res_load) begin
                    n_state = kat_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kat_pkg::S_IDLE;
            end
        endcase
    end

    // Control, configuration and tracking state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= kat_pkg::S_IDLE;
            r_out_valid       <= 1'b0;
            r_cfg_wrap_output <= 1'b0;
            r_cfg_min         <= kat_pkg::MIN_ANGLE_RST;
            r_cfg_max         <= kat_pkg::MAX_ANGLE_RST;
            r_cfg_wrap_index  <= 1'b0;
            r_cfg_stretch     <= kat_pkg::STRETCH_RST;
            r_cfg_detent      <= kat_pkg::DETENT_RST;
            r_cfg_offset      <= 12'd0;
            r_prev_raw        <= 12'd0;
            r_turns           <= 16'd0;
            r_total           <= 32'd0;
            r_out             <= 16'd0;
            r_index           <= 16'd0;
            r_last_det        <= 17'sd0;
            r_trig            <= 1'b0;
        end else begin
            r_state <= n_state;

            if (res_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    kat_pkg::CFG_WRAP_OUTPUT:  r_cfg_wrap_output <= i_cfg_data[0];
                    kat_pkg::CFG_MIN_ANGLE:    r_cfg_min         <= i_cfg_data;
                    kat_pkg::CFG_MAX_ANGLE:    r_cfg_max         <= i_cfg_data;
                    kat_pkg::CFG_WRAP_INDEX:   r_cfg_wrap_index  <= i_cfg_data[0];
                    kat_pkg::CFG_STRETCH_Q8:   r_cfg_stretch     <= i_cfg_data;
                    kat_pkg::CFG_DETENT_STEP:  r_cfg_detent      <= i_cfg_data[14:0];
                    kat_pkg::CFG_INDEX_OFFSET: r_cfg_offset      <= i_cfg_data[11:0];
                    default: begin
                    end
                endcase
            end

            unique case (r_state)
                kat_pkg::S_UNWRAP: begin
                    r_prev_raw <= r_raw;
                    if (r_cmd) begin
                        r_total <= 32'd0;
                        r_out   <= 16'd0;
                        r_index <= 16'd0;
                    end else begin
                        if (raw_diff < -$signed(13'(kat_pkg::HALF_TURN))) begin
                            r_turns <= r_turns + 16'd1;
                        end else if (raw_diff > $signed(13'(kat_pkg::HALF_TURN))) begin
                            r_turns <= r_turns - 16'd1;
                        end
                        r_total <= r_total + {{19{n_delta[12]}}, n_delta};
                    end
                end
                kat_pkg::S_OSHAPE: begin
                    if (!r_cfg_wrap_output) begin
                        r_out <= o_clamp[15:0];
                    end
                end
                kat_pkg::S_OMOD: begin
                    if (r_cnt == 4'd0) begin
                        r_out <= n_rem[15:0];
                    end
                end
                kat_pkg::S_IDX: begin
                    r_index <= n_index;
                end
                kat_pkg::S_TRIG: begin
                    if (det_diff_abs >= {3'b000, res}) begin
                        r_trig     <= !r_trig;
                        r_last_det <= r_det;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Working registers and result register; no reset needed.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cmd <= i_cmd;
            r_raw <= i_raw_angle;
        end

        unique case (r_state)
            kat_pkg::S_UNWRAP: begin
                if (r_cmd) begin
                    r_delta <= 13'sd0;
                    r_tidx  <= r_cfg_offset;
                    r_det   <= r_last_det;
                end else begin
                    r_delta <= n_delta;
                    r_o     <= n_o;
                end
            end
            kat_pkg::S_OSHAPE: begin
                r_rem <= o_biased;
                r_cnt <= 4'(kat_pkg::MOD_STEPS - 1);
            end
            kat_pkg::S_OMOD, kat_pkg::S_IMOD: begin
                r_rem <= n_rem;
                r_cnt <= r_cnt - 4'd1;
                if ((r_state == kat_pkg::S_IMOD) && (r_cnt == 4'd0)) begin
                    r_tidx <= n_rem[11:0];
                end
            end
            kat_pkg::S_MUL: begin
                r_prod <= mul_p;
            end
            kat_pkg::S_IDX: begin
                r_rem  <= idx_biased;
                r_cnt  <= 4'(kat_pkg::MOD_STEPS - 1);
                r_tidx <= idx_clamp;
            end
            kat_pkg::S_DIVPREP: begin
                r_quo <= div_num[15:0];
                r_rem <= 17'd0;
                r_cnt <= 4'(kat_pkg::DIV_STEPS - 1);
            end
            kat_pkg::S_DIV: begin
                r_rem <= n_rem;
                r_quo <= {r_quo[14:0], sub_ge};
                r_cnt <= r_cnt - 4'd1;
            end
            kat_pkg::S_DMUL: begin
                r_det <= r_out[15] ? 17'(-{1'b0, det_mag}) : {1'b0, det_mag};
            end
            default: begin
            end
        endcase

        if (res_load) begin
            r_res_step   <= r_delta[11:0];
            r_res_turns  <= r_turns;
            r_res_total  <= r_total;
            r_res_shaped <= r_out;
            r_res_tidx   <= r_tidx;
            r_res_det    <= r_det;
            r_res_trig   <= r_trig;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_step_delta   = r_res_step;
    assign o_turn_count   = r_res_turns;
    assign o_total_angle  = r_res_total;
    assign o_shaped_angle = r_res_shaped;
    assign o_table_index  = r_res_tidx;
    assign o_detent_angle = r_res_det;
    assign o_trigger_bit  = r_res_trig;

    // An accepted request keeps the block busy in the following cycle.
    `KAT_ASSERT_NEXT(a_busy_after_req, in_accept, o_in_stall, "request accepted but block not busy")
    // A new result appears only out of the final sequencer state.
    `KAT_ASSERT_NOW(a_res_from_done, $rose(r_out_valid),
        $past(r_state == kat_pkg::S_DONE), "result loaded outside final state")
    // The trigger changes only in the detent compare step.
    `KAT_ASSERT_NOW(a_trig_in_step, r_trig != $past(r_trig),
        $past(r_state == kat_pkg::S_TRIG), "trigger toggled outside compare step")
    // A wrapped output angle is fully reduced before the stretch step.
    `KAT_ASSERT_NOW(a_out_reduced, (r_state == kat_pkg::S_MUL) && r_cfg_wrap_output,
        r_out < OUT_SPAN, "wrapped output angle not reduced")

endmodule
